### src/utf8ss_pkg.sv
// Shared types and constants of the UTF-8 stream sanitiser.
// Used by utf8ss_front, utf8ss_queue and utf8_stream_sanitiser_unit; no dependencies.
package utf8ss_pkg;

	// Replacement character and the class limits of the strict UTF-8 ranges.
	localparam logic [7:0] QMARK      = 8'h3F;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] TAIL_LO    = 8'h80;
	localparam logic [7:0] TAIL_HI    = 8'hBF;

	// One accepted byte gives at most this many result bytes.
	localparam int MaxPerItem = 4;
	localparam int NumW       = $clog2(MaxPerItem + 1);

	// Result queue between the front and the output.
	localparam int QDepth = 8;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [2:0] len;  // sequence length, 0 when the byte is no multi-byte lead
		logic [7:0] lo;   // allowed range of the first tail
		logic [7:0] hi;
	} lead_t;

	// Result bytes of one accepted input byte, written to the queue at once.
	typedef struct packed {
		logic [NumW-1:0]                  num;
		logic [MaxPerItem-1:0][7:0]       bytes;
		logic [MaxPerItem-1:0]            last;
	} wr_t;

endpackage

### src/utf8ss_front.sv
// Front of the UTF-8 stream sanitiser: holds pending bytes and classifies each window.
// Depends on utf8ss_pkg; produces one utf8ss_pkg::wr_t per accepted byte.
module utf8ss_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output utf8ss_pkg::wr_t   wr
);

	logic [2:0][7:0]                                held_q;
	logic [1:0]                                     held_cnt_q;
	logic [utf8ss_pkg::MaxPerItem-1:0][7:0]         win;
	logic [utf8ss_pkg::MaxPerItem-1:0]              rep;
	logic [2:0]                                     n;
	logic [2:0]                                     pos;
	logic [2:0]                                     idx;
	logic [2:0]                                     pos_last;
	logic                                           stop;
	logic                                           ok;
	logic [7:0]                                     c;
	logic [7:0]                                     t1;
	logic [7:0]                                     t2;
	logic [7:0]                                     t3;
	utf8ss_pkg::lead_t                              lc;
	logic [2:0][7:0]                                held_d;
	logic [2:0]                                     held_cnt_d;
	logic                                           accept;

	function automatic utf8ss_pkg::lead_t lead_class(input logic [7:0] b);
		utf8ss_pkg::lead_t r;
		r.len = 3'd0;
		r.lo  = utf8ss_pkg::TAIL_LO;
		r.hi  = utf8ss_pkg::TAIL_HI;
		case (b) inside
			[8'hC2:8'hDF]: r.len = 3'd2;
			8'hE0: begin
				r.len = 3'd3;
				r.lo  = 8'hA0;
			end
			[8'hE1:8'hEC], [8'hEE:8'hEF]: r.len = 3'd3;
			8'hED: begin
				r.len = 3'd3;
				r.hi  = 8'h9F;
			end
			8'hF0: begin
				r.len = 3'd4;
				r.lo  = 8'h90;
			end
			[8'hF1:8'hF3]: r.len = 3'd4;
			8'hF4: begin
				r.len = 3'd4;
				r.hi  = 8'h8F;
			end
			default: r.len = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_tail(input logic [7:0] b);
		return (b >= utf8ss_pkg::TAIL_LO) && (b <= utf8ss_pkg::TAIL_HI);
	endfunction

	assign accept = push && !full;

	// Window: pending bytes first, then the new byte; unused lanes are zero.
	always_comb begin
		for (int i = 0; i < utf8ss_pkg::MaxPerItem; i++) begin
			if (i < 3 && 2'(i) < held_cnt_q) begin
				win[i] = held_q[i[1:0]];
			end else if (3'(i) == {1'b0, held_cnt_q}) begin
				win[i] = in_byte;
			end else begin
				win[i] = 8'h00;
			end
		end
	end

	assign n = {1'b0, held_cnt_q} + 3'd1;

	// Every consumed byte yields exactly one result at its own position, so the
	// scan only decides how far it gets and which positions become '?'.
	always_comb begin
		pos  = 3'd0;
		stop = 1'b0;
		rep  = '0;
		c    = 8'h00;
		t1   = 8'h00;
		t2   = 8'h00;
		t3   = 8'h00;
		ok   = 1'b0;
		idx  = 3'd0;
		lc   = lead_class(8'h00);
		for (int it = 0; it < utf8ss_pkg::MaxPerItem; it++) begin
			if (!stop && pos < n) begin
				c  = win[pos[1:0]];
				lc = lead_class(c);
				idx = pos + 3'd1;
				t1 = win[idx[1:0]];
				idx = pos + 3'd2;
				t2 = win[idx[1:0]];
				idx = pos + 3'd3;
				t3 = win[idx[1:0]];
				if (c < utf8ss_pkg::CTRL_LIMIT) begin
					rep[pos[1:0]] = 1'b1;
					pos = pos + 3'd1;
				end else if (c <= utf8ss_pkg::ASCII_MAX) begin
					pos = pos + 3'd1;
				end else if (lc.len == 3'd0) begin
					rep[pos[1:0]] = 1'b1;
					pos = pos + 3'd1;
				end else if (pos + lc.len > n) begin
					// Sequence not complete yet: give up at end of stream, else wait.
					if (in_last) begin
						rep[pos[1:0]] = 1'b1;
						pos = pos + 3'd1;
					end else begin
						stop = 1'b1;
					end
				end else begin
					ok = (t1 >= lc.lo) && (t1 <= lc.hi);
					if (lc.len >= 3'd3 && !is_tail(t2)) begin
						ok = 1'b0;
					end
					if (lc.len == 3'd4 && !is_tail(t3)) begin
						ok = 1'b0;
					end
					if (ok) begin
						pos = pos + lc.len;
					end else begin
						rep[pos[1:0]] = 1'b1;
						pos = pos + 3'd1;
					end
				end
			end
		end
	end

	// Unconsumed bytes move to the front of the hold buffer.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			held_d[i] = win[2'(pos + 3'(i))];
		end
		held_cnt_d = n - pos;
	end

	assign pos_last = pos - 3'd1;

	always_comb begin
		wr.num = accept ? pos : 3'd0;
		for (int i = 0; i < utf8ss_pkg::MaxPerItem; i++) begin
			wr.bytes[i] = rep[i] ? utf8ss_pkg::QMARK : win[i];
			wr.last[i]  = in_last && (pos_last == 3'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= held_cnt_d[1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

### src/utf8ss_queue.sv
// Result queue of the UTF-8 stream sanitiser: takes up to four bytes per cycle, gives one.
// Depends on utf8ss_pkg for its depth and for the write bundle utf8ss_pkg::wr_t.
module utf8ss_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  utf8ss_pkg::wr_t   wr,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              out_last
);

	logic [utf8ss_pkg::QDepth-1:0][7:0]   byte_q;
	logic [utf8ss_pkg::QDepth-1:0]        last_q;
	logic [utf8ss_pkg::QPtrW-1:0]         wr_ptr_q;
	logic [utf8ss_pkg::QPtrW-1:0]         rd_ptr_q;
	logic [utf8ss_pkg::QCntW-1:0]         cnt_q;
	logic                                 pop_ok;

	// The front may only write when a whole item's worth of entries is free.
	assign full     = cnt_q > utf8ss_pkg::QCntW'(utf8ss_pkg::QDepth - utf8ss_pkg::MaxPerItem);
	assign empty    = cnt_q == '0;
	assign pop_ok   = pop && !empty;
	assign out_byte = byte_q[rd_ptr_q];
	assign out_last = last_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + utf8ss_pkg::QPtrW'(wr.num);
			rd_ptr_q <= rd_ptr_q + utf8ss_pkg::QPtrW'(pop_ok);
			cnt_q    <= cnt_q + utf8ss_pkg::QCntW'(wr.num) - utf8ss_pkg::QCntW'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < utf8ss_pkg::MaxPerItem; i++) begin
			if (utf8ss_pkg::NumW'(i) < wr.num) begin
				byte_q[wr_ptr_q + utf8ss_pkg::QPtrW'(i)] <= wr.bytes[i];
				last_q[wr_ptr_q + utf8ss_pkg::QPtrW'(i)] <= wr.last[i];
			end
		end
	end

endmodule

### src/utf8_stream_sanitiser_unit.sv
// UTF-8 stream sanitiser top level: sanitises a byte stream into a stream of equal length.
// Depends on utf8ss_pkg, utf8ss_front and utf8ss_queue.
//
// Input side: a byte and its last marker are taken in a transaction when push
// is high and full is low. Output side: while empty is low the oldest result
// byte sits on out_byte/out_last and leaves in a transaction when pop is high.
// Each input byte yields exactly one output byte, either unchanged or '?'.
// With nothing pending, an ASCII, control or bad-lead byte is written into the
// queue at its transaction and can leave it in the next cycle. Lead and tail
// bytes of a multi-byte sequence, and any byte behind them, are held in the
// front, up to three of them, until enough bytes for the whole sequence have
// arrived or the stream ends; the results then go into the queue at that transaction.
// Throughput is one byte per cycle sustained while the receiver keeps pop high; the
// front writes up to four results per cycle into an eight-entry queue and full is
// raised while more than four entries are occupied. When the receiver stalls, the
// queue fills and full stops the sender without losing any byte.
// Reset drops the pending bytes and empties the queue.
module utf8_stream_sanitiser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	utf8ss_pkg::wr_t wr;

	utf8ss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_byte (in_byte),
		.in_last (in_last),
		.wr      (wr)
	);

	utf8ss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule
